FILE: rtl/core/u8u16_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16BE transcoder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_message;
    logic       last_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_error;
    logic [2:0] error_code;
    logic       end_of_run;
    logic       end_of_message;
  } out_word_t;

  typedef enum logic [2:0] {
    ERR_BAD_LEAD = 3'd0,
    ERR_BAD_CONT = 3'd1,
    ERR_OVERLONG = 3'd2,
    ERR_RANGE    = 3'd3,
    ERR_SURR     = 3'd4,
    ERR_TRUNC    = 3'd5,
    ERR_CAPACITY = 3'd6
  } err_code_t;

  typedef enum logic [1:0] {
    JOB_ERR  = 2'd0,
    JOB_UNIT = 2'd1,
    JOB_PAIR = 2'd2
  } job_kind_t;

  // One decoded code point or error, handed from front to back
  typedef struct packed {
    job_kind_t  kind;
    logic [15:0] unit0;
    logic [15:0] unit1;
    err_code_t  code;
    logic       last;
  } job_t;

  localparam int unsigned CAP_WIDTH   = 12;
  localparam logic [11:0] CAP_RESET   = 12'd200;
  localparam logic [20:0] CP_MIN_2    = 21'h80;
  localparam logic [20:0] CP_MIN_3    = 21'h800;
  localparam logic [20:0] CP_MIN_4    = 21'h10000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] SURR_LO     = 21'hD800;
  localparam logic [20:0] SURR_HI     = 21'hDFFF;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

endpackage

`default_nettype wire

FILE: rtl/core/utf8_to_utf16be_transcoder.sv
// Top level of the UTF-8 to UTF-16BE transcoder: front end, job queue, back end.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one UTF-8 byte per cycle while full is low and decodes it at
// once in the front end; each finished code point or error becomes one job in a
// four-entry queue. The back end gives one output word per cycle from the head
// job while pop is high: a code point up to 0xFFFF yields two bytes, a
// supplementary one four (a surrogate pair), an error one word with is_error
// set. Input keeps pace while output averages one byte per input byte; full
// rises when four jobs wait. cfg_data sets the per-message byte capacity (reset
// 200); the user must write it only while idle; the block does not enforce it.

module utf8_to_utf16be_transcoder
  import u8u16_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire in_word_t             in_item,
  output logic                      empty,
  input  wire logic                 pop,
  output out_word_t                 out_item,
  input  wire logic                 cfg_write,
  input  wire logic [CAP_WIDTH-1:0] cfg_data
);

  logic accept;
  logic job_valid;
  job_t job;
  job_t head;
  logic head_done;

  assign accept = push && !full;

  u8u16_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (in_item),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .job_valid(job_valid),
    .job      (job)
  );

  u8u16_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (job_valid),
    .wr_job(job),
    .rd_en (head_done),
    .rd_job(head),
    .full  (full),
    .empty (empty)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(!empty),
    .pop       (pop),
    .head_done (head_done),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/core/u8u16_front.sv
// Front end: accepts UTF-8 bytes, tracks the pending sequence and the message
// counters, and makes a back-end job of each code point or error. Uses u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front
  import u8u16_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire in_word_t              in_item,
  input  wire logic                  cfg_write,
  input  wire logic [CAP_WIDTH-1:0]  cfg_data,
  output logic                       job_valid,
  output job_t                       job
);

  localparam int unsigned LW = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;
  localparam logic [LW-1:0] COUNT_MAX = LW'((LW'(1) << COUNT_WIDTH) - LW'(1));

  logic [CAP_WIDTH-1:0]   capacity;
  logic [20:0]            partial;
  logic [1:0]             needed;
  logic [1:0]             seq_len;
  logic [COUNT_WIDTH-1:0] written;
  logic                   latched;

  logic [20:0]            partial_next;
  logic [1:0]             needed_next;
  logic [1:0]             seq_len_next;
  logic [COUNT_WIDTH-1:0] written_next;
  logic                   latched_next;

  logic [20:0]            p_eff;
  logic [1:0]             n_eff;
  logic [1:0]             s_eff;
  logic [COUNT_WIDTH-1:0] w_eff;
  logic                   l_eff;

  logic [7:0]             b;
  logic                   err;
  err_code_t              code;
  logic                   complete;
  logic                   data_ok;
  logic [20:0]            cp;
  logic [20:0]            cp_off;
  logic [LW-1:0]          limit;
  logic [LW-1:0]          sum;
  logic [LW-1:0]          cap_ext;
  logic                   is_pair;

  always_comb begin
    b       = in_item.in_byte;
    p_eff   = in_item.first_of_message ? '0 : partial;
    n_eff   = in_item.first_of_message ? '0 : needed;
    s_eff   = in_item.first_of_message ? '0 : seq_len;
    w_eff   = in_item.first_of_message ? '0 : written;
    l_eff   = in_item.first_of_message ? 1'b0 : latched;

    partial_next = p_eff;
    needed_next  = n_eff;
    seq_len_next = s_eff;
    written_next = w_eff;
    latched_next = l_eff;
    err      = 1'b0;
    code     = ERR_BAD_LEAD;
    complete = 1'b0;
    data_ok  = 1'b0;
    cp       = '0;
    is_pair  = 1'b0;
    cap_ext  = LW'(capacity);
    limit    = (cap_ext < COUNT_MAX) ? cap_ext : COUNT_MAX;
    sum      = '0;

    if (!l_eff) begin
      if (n_eff == 2'd0) begin
        if (!b[7]) begin
          cp           = {13'd0, b};
          seq_len_next = 2'd0;
          complete     = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          if (b == 8'hC0) begin
            err  = 1'b1;
            code = ERR_BAD_LEAD;
          end else begin
            partial_next = {16'd0, b[4:0]};
            needed_next  = 2'd1;
            seq_len_next = 2'd1;
          end
        end else if (b[7:4] == 4'b1110) begin
          partial_next = {17'd0, b[3:0]};
          needed_next  = 2'd2;
          seq_len_next = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          partial_next = {18'd0, b[2:0]};
          needed_next  = 2'd3;
          seq_len_next = 2'd3;
        end else begin
          err  = 1'b1;
          code = ERR_BAD_LEAD;
        end
      end else begin
        if (b[7:6] != 2'b10) begin
          err  = 1'b1;
          code = ERR_BAD_CONT;
        end else begin
          partial_next = {p_eff[14:0], b[5:0]};
          needed_next  = n_eff - 2'd1;
          if (n_eff == 2'd1) begin
            cp       = partial_next;
            complete = 1'b1;
          end
        end
      end

      if (!err && !complete && in_item.last_of_message) begin
        err  = 1'b1;
        code = ERR_TRUNC;
      end

      if (complete) begin
        is_pair = cp > 21'hFFFF;
        sum     = LW'(w_eff) + (is_pair ? LW'(4) : LW'(2));
        if ((s_eff == 2'd1 && cp < CP_MIN_2) || (s_eff == 2'd2 && cp < CP_MIN_3) ||
            (s_eff == 2'd3 && cp < CP_MIN_4)) begin
          err  = 1'b1;
          code = ERR_OVERLONG;
        end else if (cp > CP_MAX) begin
          err  = 1'b1;
          code = ERR_RANGE;
        end else if (cp >= SURR_LO && cp <= SURR_HI) begin
          err  = 1'b1;
          code = ERR_SURR;
        end else if (sum > limit) begin
          err  = 1'b1;
          code = ERR_CAPACITY;
        end else begin
          data_ok      = 1'b1;
          written_next = sum[COUNT_WIDTH-1:0];
        end
        partial_next = '0;
        seq_len_next = '0;
      end

      if (err) begin
        latched_next = 1'b1;
        partial_next = '0;
        needed_next  = '0;
        seq_len_next = '0;
      end
    end

    cp_off    = cp - CP_MIN_4;
    job_valid = accept && (err || data_ok);
    job.code  = code;
    job.last  = in_item.last_of_message;
    if (err) begin
      job.kind  = JOB_ERR;
      job.unit0 = '0;
      job.unit1 = '0;
    end else if (is_pair) begin
      job.kind  = JOB_PAIR;
      job.unit0 = {HI_SURR_TAG, cp_off[19:10]};
      job.unit1 = {LO_SURR_TAG, cp_off[9:0]};
    end else begin
      job.kind  = JOB_UNIT;
      job.unit0 = cp[15:0];
      job.unit1 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      partial  <= '0;
      needed   <= '0;
      seq_len  <= '0;
      written  <= '0;
      latched  <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        partial <= partial_next;
        needed  <= needed_next;
        seq_len <= seq_len_next;
        written <= written_next;
        latched <= latched_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/u8u16_queue.sv
// Four-entry job queue between front and back end.
// Uses u8u16_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue
  import u8u16_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      full,
  output logic      empty
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full   = count == (AW + 1)'(DEPTH);
  assign empty  = count == '0;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW + 1)'(wr_en) - (AW + 1)'(rd_en);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/u8u16_back.sv
// Back end: walks the job at the head of the queue one output word at a time.
// Uses u8u16_pkg for the job and result types.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t head,
  input  wire logic head_valid,
  input  wire logic pop,
  output logic      head_done,
  output out_word_t out_item
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       final_word;

  always_comb begin
    case (head.kind)
      JOB_UNIT: last_idx = 2'd1;
      JOB_PAIR: last_idx = 2'd3;
      default:  last_idx = 2'd0;
    endcase
    final_word = idx == last_idx;
    head_done  = pop && head_valid && final_word;

    case (idx)
      2'd0:    out_item.out_byte = head.unit0[15:8];
      2'd1:    out_item.out_byte = head.unit0[7:0];
      2'd2:    out_item.out_byte = head.unit1[15:8];
      default: out_item.out_byte = head.unit1[7:0];
    endcase
    out_item.is_error       = head.kind == JOB_ERR;
    out_item.error_code     = (head.kind == JOB_ERR) ? head.code : 3'd0;
    out_item.end_of_run     = final_word;
    out_item.end_of_message = final_word && head.last && head.kind != JOB_ERR;
  end

  // advance within the job, restart at the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && head_valid) begin
      idx <= final_word ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire
